@@ rtl/bfknn_pkg.sv @@
`default_nettype none
package bfknn_pkg;

	localparam int MAX_POINTS    = 1024;
	localparam int MAX_DIMS      = 16;
	localparam int MAX_NEIGHBORS = 16;
	localparam int COORD_BITS    = 16;

	localparam int PT_W   = $clog2(MAX_POINTS);
	localparam int DIM_W  = $clog2(MAX_DIMS);
	localparam int SLOT_W = $clog2(MAX_NEIGHBORS);
	localparam int ADDR_W = PT_W + DIM_W;
	localparam int DEPTH  = MAX_POINTS * MAX_DIMS;

	// register widths
	localparam int NP_W = 11;
	localparam int ND_W = 5;
	localparam int K_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = NP_W;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int DIST_W = SQ_W + DIM_W;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_NEIGHBORS = 2'd2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_WAIT,
		ST_FIND,
		ST_EMIT
	} bfknn_state_t;

	typedef struct packed {
		logic              wr;
		logic              clear;
		logic              rd;
		logic              rd_load;
		logic              rd_last;
		logic [PT_W-1:0]   pt;
		logic [DIM_W-1:0]  dim;
		logic              zero_dims;
		logic              replace;
		logic              find;
		logic              find_first;
		logic              emit;
		logic              emit_last;
		logic [SLOT_W-1:0] slot;
	} bfknn_cmd_t;

	typedef struct packed {
		logic dist_done;
		logic dist_lt;
		logic out_stall;
	} bfknn_stat_t;

endpackage
`default_nettype wire

@@ rtl/bfknn_ram.sv @@
`default_nettype none
module bfknn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/bfknn_dp.sv @@
`default_nettype none
module bfknn_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire bfknn_pkg::bfknn_cmd_t               cmd,
	output bfknn_pkg::bfknn_stat_t                   st,
	input  wire logic [bfknn_pkg::PT_W-1:0]          in_pt,
	input  wire logic [bfknn_pkg::DIM_W-1:0]         in_dim,
	input  wire logic [bfknn_pkg::COORD_BITS-1:0]    in_coord,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [bfknn_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	output logic                                     m_axis_tuser,
	output logic                                     m_axis_tlast
);

	localparam int CB = bfknn_pkg::COORD_BITS;
	localparam int DW = bfknn_pkg::DIST_W;
	localparam int PW = bfknn_pkg::PT_W;
	localparam int SW = bfknn_pkg::SLOT_W;

	logic [CB-1:0] rdata;

	bfknn_ram #(
		.WIDTH(CB),
		.DEPTH(bfknn_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr({in_pt, in_dim}),
		.wdata(in_coord),
		.re   (cmd.rd),
		.raddr({cmd.pt, cmd.dim}),
		.rdata(rdata)
	);

	// read pipeline: s1 = RAM data, s2 = difference, s3 = square
	logic                             rd_s1, load_s1, last_s1;
	logic [bfknn_pkg::DIM_W-1:0]      dim_s1;
	logic [CB-1:0]                    qbuf_q [bfknn_pkg::MAX_DIMS];
	logic signed [bfknn_pkg::DIFF_W-1:0] diff_s2;
	logic                             v_s2, last_s2;
	logic [bfknn_pkg::SQ_W-1:0]       sq_s3;
	logic                             v_s3, last_s3;
	logic [DW-1:0]                    acc_q, dist_q, acc_sum;
	logic                             done_q;

	logic signed [bfknn_pkg::DIFF_W-1:0]   a_ext, q_ext;
	logic signed [2*bfknn_pkg::DIFF_W-1:0] prod;
	logic [CB-1:0]                         qsel;

	assign qsel    = qbuf_q[dim_s1];
	assign a_ext   = $signed({rdata[CB-1], rdata});
	assign q_ext   = $signed({qsel[CB-1], qsel});
	assign prod    = diff_s2 * diff_s2;
	assign acc_sum = acc_q + DW'(sq_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			load_s1 <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			v_s3    <= 1'b0;
			last_s3 <= 1'b0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			rd_s1   <= cmd.rd;
			load_s1 <= cmd.rd_load;
			last_s1 <= cmd.rd_last;
			v_s2    <= rd_s1 && !load_s1;
			last_s2 <= last_s1;
			v_s3    <= v_s2;
			last_s3 <= last_s2;
			done_q  <= v_s3 && last_s3;
			if (v_s3) begin
				acc_q <= last_s3 ? '0 : acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		dim_s1  <= cmd.dim;
		diff_s2 <= cmd.zero_dims ? '0 : a_ext - q_ext;
		sq_s3   <= prod[bfknn_pkg::SQ_W-1:0];
		if (rd_s1 && load_s1) begin
			qbuf_q[dim_s1] <= rdata;
		end
		if (v_s3 && last_s3) begin
			dist_q <= acc_sum;
		end
	end

	// neighbor slots; an unfilled slot counts as infinitely far
	logic [DW-1:0]                     best_dist_q [bfknn_pkg::MAX_NEIGHBORS];
	logic [PW-1:0]                     best_idx_q  [bfknn_pkg::MAX_NEIGHBORS];
	logic [bfknn_pkg::MAX_NEIGHBORS-1:0] filled_q;
	logic [SW-1:0]                     worst_q;
	logic [DW-1:0]                     wv_dist_q;
	logic                              wv_filled_q;

	logic [DW-1:0] rd_dist;
	logic [PW-1:0] rd_idx;
	logic          rd_fill, greater;

	assign rd_dist = best_dist_q[cmd.slot];
	assign rd_idx  = best_idx_q[cmd.slot];
	assign rd_fill = filled_q[cmd.slot];
	assign greater = (!rd_fill && wv_filled_q) ||
		(rd_fill && wv_filled_q && (rd_dist > wv_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q    <= '0;
			worst_q     <= '0;
			wv_filled_q <= 1'b0;
		end else if (cmd.clear) begin
			filled_q    <= '0;
			worst_q     <= '0;
			wv_filled_q <= 1'b0;
		end else if (cmd.replace) begin
			filled_q[worst_q] <= 1'b1;
		end else if (cmd.find) begin
			if (cmd.find_first || greater) begin
				worst_q     <= cmd.slot;
				wv_filled_q <= rd_fill;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.replace) begin
			best_dist_q[worst_q] <= dist_q;
			best_idx_q[worst_q]  <= cmd.pt;
		end
		if (cmd.find && (cmd.find_first || greater)) begin
			wv_dist_q <= rd_dist;
		end
	end

	// output register
	logic          out_valid_q;
	logic [SW-1:0] out_slot_q;
	logic [PW-1:0] out_idx_q;
	logic [DW-1:0] out_dist_q;
	logic          out_found_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_slot_q  <= cmd.slot;
			out_idx_q   <= rd_fill ? rd_idx : '0;
			out_dist_q  <= rd_fill ? rd_dist : '0;
			out_found_q <= rd_fill;
			out_last_q  <= cmd.emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(bfknn_pkg::OUT_DATA_W - DW - PW - SW)'(0),
		out_dist_q, out_idx_q, out_slot_q};
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tlast  = out_last_q;

	assign st.dist_done = done_q;
	assign st.dist_lt   = !wv_filled_q || (dist_q < wv_dist_q);
	assign st.out_stall = out_valid_q && !m_axis_tready;

	a_replace_closer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.replace |-> st.dist_lt)
		else $error("slot replaced by a distance that is not closer");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (filled_q == '0 && !wv_filled_q))
		else $error("slots not empty after query start");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !st.out_stall)
		else $error("result overwritten while stalled");

endmodule
`default_nettype wire

@@ rtl/bfknn_ctrl.sv @@
`default_nettype none
module bfknn_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic                                in_func,
	input  wire logic [bfknn_pkg::PT_W-1:0]          in_pt,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bfknn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bfknn_pkg::CFG_DATA_W-1:0]    cfg_data,
	output bfknn_pkg::bfknn_cmd_t                    cmd,
	input  wire bfknn_pkg::bfknn_stat_t              st
);

	localparam int PW = bfknn_pkg::PT_W;
	localparam int DM = bfknn_pkg::DIM_W;
	localparam int SW = bfknn_pkg::SLOT_W;
	localparam int NPW = bfknn_pkg::NP_W;
	localparam int NDW = bfknn_pkg::ND_W;
	localparam int KW = bfknn_pkg::K_W;

	bfknn_pkg::bfknn_state_t state_q, state_d;

	logic [PW-1:0]  pi_q, pi_d, j_q, j_d;
	logic [DM-1:0]  d_q, d_d;
	logic [SW-1:0]  s_q, s_d;
	logic [NPW-1:0] num_points_q;
	logic [NDW-1:0] num_dims_q;
	logic [KW-1:0]  num_neighbors_q;

	logic [NPW-1:0] np_eff;
	logic [NDW-1:0] nd_eff;
	logic [KW-1:0]  k_eff;
	logic [DM-1:0]  d_last;
	logic [SW-1:0]  s_last;
	logic           j_end, query_oob;

	assign np_eff = (num_points_q > NPW'(bfknn_pkg::MAX_POINTS)) ?
		NPW'(bfknn_pkg::MAX_POINTS) : num_points_q;
	assign nd_eff = (num_dims_q > NDW'(bfknn_pkg::MAX_DIMS)) ?
		NDW'(bfknn_pkg::MAX_DIMS) : num_dims_q;
	assign k_eff = (num_neighbors_q == '0) ? KW'(1) :
		(num_neighbors_q > KW'(bfknn_pkg::MAX_NEIGHBORS)) ?
		KW'(bfknn_pkg::MAX_NEIGHBORS) : num_neighbors_q;

	// zero dims still runs one read per point, with the term forced to zero
	assign d_last    = (nd_eff == '0) ? '0 : DM'(nd_eff - NDW'(1));
	assign s_last    = SW'(k_eff - KW'(1));
	assign j_end     = ({1'b0, j_q} == (np_eff - NPW'(1)));
	assign query_oob = ({1'b0, in_pt} >= np_eff);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q    <= NPW'(1024);
			num_dims_q      <= NDW'(16);
			num_neighbors_q <= KW'(4);
		end else if (cfg_valid) begin
			case (cfg_index)
				bfknn_pkg::CFG_NUM_POINTS: num_points_q <= cfg_data;
				bfknn_pkg::CFG_NUM_DIMS: num_dims_q <= cfg_data[NDW-1:0];
				bfknn_pkg::CFG_NUM_NEIGHBORS: num_neighbors_q <= cfg_data[KW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfknn_pkg::ST_IDLE;
			pi_q    <= '0;
			j_q     <= '0;
			d_q     <= '0;
			s_q     <= '0;
		end else begin
			state_q <= state_d;
			pi_q    <= pi_d;
			j_q     <= j_d;
			d_q     <= d_d;
			s_q     <= s_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pi_d    = pi_q;
		j_d     = j_q;
		d_d     = d_q;
		s_d     = s_q;
		s_axis_tready = 1'b0;
		cmd = '0;
		cmd.pt        = j_q;
		cmd.dim       = d_q;
		cmd.slot      = s_q;
		cmd.zero_dims = (nd_eff == '0);

		case (state_q)
			bfknn_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (in_func == bfknn_pkg::FUNC_WRITE) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.clear = 1'b1;
						pi_d = in_pt;
						j_d  = '0;
						d_d  = '0;
						s_d  = '0;
						state_d = query_oob ? bfknn_pkg::ST_EMIT : bfknn_pkg::ST_LOAD;
					end
				end
			end
			bfknn_pkg::ST_LOAD: begin
				cmd.rd      = 1'b1;
				cmd.rd_load = 1'b1;
				cmd.pt      = pi_q;
				if (d_q == d_last) begin
					d_d = '0;
					state_d = bfknn_pkg::ST_SCAN;
				end else begin
					d_d = d_q + DM'(1);
				end
			end
			bfknn_pkg::ST_SCAN: begin
				if (j_q == pi_q) begin
					if (j_end) begin
						state_d = bfknn_pkg::ST_EMIT;
					end else begin
						j_d = j_q + PW'(1);
					end
				end else begin
					cmd.rd      = 1'b1;
					cmd.rd_last = (d_q == d_last);
					if (d_q == d_last) begin
						d_d = '0;
						state_d = bfknn_pkg::ST_WAIT;
					end else begin
						d_d = d_q + DM'(1);
					end
				end
			end
			bfknn_pkg::ST_WAIT: begin
				if (st.dist_done) begin
					if (st.dist_lt) begin
						cmd.replace = 1'b1;
						s_d = '0;
						state_d = bfknn_pkg::ST_FIND;
					end else if (j_end) begin
						state_d = bfknn_pkg::ST_EMIT;
					end else begin
						j_d = j_q + PW'(1);
						state_d = bfknn_pkg::ST_SCAN;
					end
				end
			end
			bfknn_pkg::ST_FIND: begin
				// first slot holding the largest distance, one slot a cycle
				cmd.find       = 1'b1;
				cmd.find_first = (s_q == '0);
				if (s_q == s_last) begin
					s_d = '0;
					if (j_end) begin
						state_d = bfknn_pkg::ST_EMIT;
					end else begin
						j_d = j_q + PW'(1);
						state_d = bfknn_pkg::ST_SCAN;
					end
				end else begin
					s_d = s_q + SW'(1);
				end
			end
			bfknn_pkg::ST_EMIT: begin
				if (!st.out_stall) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = (s_q == s_last);
					if (s_q == s_last) begin
						s_d = '0;
						state_d = bfknn_pkg::ST_IDLE;
					end else begin
						s_d = s_q + SW'(1);
					end
				end
			end
			default: begin
				state_d = bfknn_pkg::ST_IDLE;
			end
		endcase
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.dist_done |-> (state_q == bfknn_pkg::ST_WAIT))
		else $error("distance finished outside the wait state");

	a_no_self: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd && !cmd.rd_load) |-> (cmd.pt != pi_q))
		else $error("query point scanned against itself");

endmodule
`default_nettype wire

@@ rtl/brute_force_knn_search_unit.sv @@
`default_nettype none
// Write item: stored, no result. Query out of range: K empty results. One item at a time.
// Query item: compares every other point with the query point and emits K results,
// stalling on result back-pressure, where K is num_neighbors after saturation. Each
// slot replacement runs a worst-slot search over the K slots. The point store has a
// single read port (one coordinate a cycle) feeding the 3-stage distance pipeline.
// Reset: asynchronous, active low; registers to 1024 / 16 / 4, slots empty, store undefined.
module brute_force_knn_search_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// point_index[9:0], dim_index[13:10], coord[29:14], zero pad
	input  wire logic [bfknn_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// func
	input  wire logic                                 s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// slot[3:0], neighbor_index[13:4], dist_sq[49:14], zero pad
	output logic [bfknn_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	// found
	output logic                                      m_axis_tuser,
	output logic                                      m_axis_tlast,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [bfknn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bfknn_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PW = bfknn_pkg::PT_W;
	localparam int DM = bfknn_pkg::DIM_W;
	localparam int CB = bfknn_pkg::COORD_BITS;

	bfknn_pkg::bfknn_cmd_t  cmd;
	bfknn_pkg::bfknn_stat_t st;

	logic [PW-1:0] in_pt;
	logic [DM-1:0] in_dim;
	logic [CB-1:0] in_coord;

	assign in_pt    = s_axis_tdata[PW-1:0];
	assign in_dim   = s_axis_tdata[PW+DM-1:PW];
	assign in_coord = s_axis_tdata[PW+DM+CB-1:PW+DM];

	bfknn_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.in_func      (s_axis_tuser),
		.in_pt        (in_pt),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.st           (st)
	);

	bfknn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.in_pt        (in_pt),
		.in_dim       (in_dim),
		.in_coord     (in_coord),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
`default_nettype wire
